// ===== hdl/rbpd_pkg.sv =====
// Shared types and constants for the ring-buffered packet deframer.
// No dependencies; all files of the block but the rx and tx interfaces refer to this package.
`default_nettype none

package rbpd_pkg;

    localparam int BUFFER_DEPTH_DEF = 64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_LENGTH  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH  = 2'd2;

    localparam logic [7:0] HEADER_BYTE_RST = 8'd170;
    localparam logic [5:0] MIN_LENGTH_RST  = 6'd3;
    localparam logic [5:0] MAX_LENGTH_RST  = 6'd63;
    localparam logic [5:0] MIN_LENGTH_FLOOR = 6'd3;

    typedef struct packed {
        logic [7:0] packet_byte;
        logic       last_of_packet;
        logic [5:0] packet_length;
    } beat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GATE,
        ST_HEAD,
        ST_LEN,
        ST_SUM,
        ST_EMIT
    } front_state_t;

endpackage

`default_nettype wire

// ===== hdl/rbpd_in_if.sv =====
// Receive channel: one received byte per beat.
// Depends on nothing.
`default_nettype none

interface rbpd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

// ===== hdl/rbpd_out_if.sv =====
// Packet output channel: one validated packet byte per beat.
// Depends on nothing.
`default_nettype none

interface rbpd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packet_byte;
    logic       last_of_packet;
    logic [5:0] packet_length;

    modport source (output valid, output packet_byte, output last_of_packet,
                    output packet_length, input ready);
    modport sink (input valid, input packet_byte, input last_of_packet,
                  input packet_length, output ready);
endinterface

`default_nettype wire

// ===== hdl/rbpd_cfg_if.sv =====
// Configuration write channel: register index and write data per beat.
// Depends on rbpd_pkg for the field widths.
`default_nettype none

interface rbpd_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [rbpd_pkg::CFG_INDEX_W-1:0]   index;
    logic [rbpd_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/rbpd_front.sv =====
// Front end: ring buffer, configuration registers and the parse sequencer
// that validates packets and pushes their bytes into the beat queue.
// Depends on rbpd_pkg, rbpd_in_if and rbpd_cfg_if.
`default_nettype none

module rbpd_front #(
    parameter int BUFFER_DEPTH = rbpd_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    rbpd_in_if.sink             rx,
    rbpd_cfg_if.sink            cfg,
    output logic                push_valid,
    output rbpd_pkg::beat_t     push_beat,
    input  wire logic           queue_full
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);
    localparam int SUM_W = ((PTR_W > 6) ? PTR_W : 6) + 1;
    localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] base,
                                                  input logic [5:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(base) + SUM_W'(off);
        if (s >= SUM_W'(BUFFER_DEPTH))
        begin
            s = s - SUM_W'(BUFFER_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    logic [7:0]             mem [BUFFER_DEPTH];
    logic [7:0]             rdata_reg;
    logic [PTR_W-1:0]       raddr;

    rbpd_pkg::front_state_t state_reg, state_next;
    logic [PTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0]       fill_reg, fill_next;
    logic [5:0]             len_reg, len_next;
    logic [5:0]             idx_reg, idx_next;
    logic [7:0]             sum_reg, sum_next;
    logic [7:0]             header_reg;
    logic [5:0]             min_reg;
    logic [5:0]             max_reg;

    logic                   accept;
    logic                   wr_en;
    logic [5:0]             min_eff;
    logic [CMP_W-1:0]       fill_cmp;
    logic [CMP_W-1:0]       rdata_cmp;
    logic                   gate_ok;
    logic                   head_bad;
    logic                   len_bad;
    logic                   len_short;
    logic                   is_last;
    logic                   sum_bad;

    assign rx.ready  = (state_reg == rbpd_pkg::ST_IDLE);
    assign cfg.ready = 1'b1;
    assign accept    = rx.valid && rx.ready;
    assign wr_en     = accept && (fill_reg < CNT_W'(BUFFER_DEPTH));

    assign min_eff   = (min_reg < rbpd_pkg::MIN_LENGTH_FLOOR) ? rbpd_pkg::MIN_LENGTH_FLOOR
                                                              : min_reg;
    assign fill_cmp  = CMP_W'(fill_reg);
    assign rdata_cmp = CMP_W'(rdata_reg);
    assign gate_ok   = fill_cmp >= CMP_W'(min_eff);
    assign head_bad  = rdata_reg != header_reg;
    assign len_bad   = (rdata_cmp < CMP_W'(min_eff)) || (rdata_reg > {2'b00, max_reg})
                       || (rdata_cmp > CMP_W'(BUFFER_DEPTH));
    assign len_short = fill_cmp < rdata_cmp;
    assign is_last   = idx_reg == (len_reg - 6'd1);
    assign sum_bad   = sum_reg != rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= rx.rx_byte;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg <= rbpd_pkg::HEADER_BYTE_RST;
            min_reg    <= rbpd_pkg::MIN_LENGTH_RST;
            max_reg    <= rbpd_pkg::MAX_LENGTH_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                rbpd_pkg::CFG_HEADER_BYTE: header_reg <= cfg.data;
                rbpd_pkg::CFG_MIN_LENGTH:  min_reg    <= cfg.data[5:0];
                rbpd_pkg::CFG_MAX_LENGTH:  max_reg    <= cfg.data[5:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rbpd_pkg::ST_IDLE;
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        idx_reg <= idx_next;
        sum_reg <= sum_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rbpd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = rbpd_pkg::ST_GATE;
                end
            end
            rbpd_pkg::ST_GATE:
            begin
                state_next = gate_ok ? rbpd_pkg::ST_HEAD : rbpd_pkg::ST_IDLE;
            end
            rbpd_pkg::ST_HEAD:
            begin
                state_next = head_bad ? rbpd_pkg::ST_GATE : rbpd_pkg::ST_LEN;
            end
            rbpd_pkg::ST_LEN:
            begin
                if (len_bad)
                begin
                    state_next = rbpd_pkg::ST_GATE;
                end
                else if (len_short)
                begin
                    state_next = rbpd_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rbpd_pkg::ST_SUM;
                end
            end
            rbpd_pkg::ST_SUM:
            begin
                if (is_last)
                begin
                    state_next = sum_bad ? rbpd_pkg::ST_GATE : rbpd_pkg::ST_EMIT;
                end
            end
            rbpd_pkg::ST_EMIT:
            begin
                if (!queue_full && is_last)
                begin
                    state_next = rbpd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rbpd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        fill_next   = fill_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        sum_next    = sum_reg;
        raddr       = rd_ptr_reg;
        push_valid  = 1'b0;
        push_beat.packet_byte    = rdata_reg;
        push_beat.last_of_packet = is_last;
        push_beat.packet_length  = len_reg;
        unique case (state_reg)
            rbpd_pkg::ST_IDLE:
            begin
                if (wr_en)
                begin
                    wr_ptr_next = wrap_add(wr_ptr_reg, 6'd1);
                    fill_next   = fill_reg + CNT_W'(1);
                end
            end
            rbpd_pkg::ST_GATE:
            begin
                raddr = rd_ptr_reg;
            end
            rbpd_pkg::ST_HEAD:
            begin
                if (head_bad)
                begin
                    rd_ptr_next = wrap_add(rd_ptr_reg, 6'd1);
                    fill_next   = fill_reg - CNT_W'(1);
                end
                else
                begin
                    raddr = wrap_add(rd_ptr_reg, 6'd1);
                end
            end
            rbpd_pkg::ST_LEN:
            begin
                if (len_bad)
                begin
                    rd_ptr_next = wrap_add(rd_ptr_reg, 6'd1);
                    fill_next   = fill_reg - CNT_W'(1);
                end
                else if (!len_short)
                begin
                    len_next = rdata_reg[5:0];
                    idx_next = '0;
                    sum_next = '0;
                    raddr    = rd_ptr_reg;
                end
            end
            rbpd_pkg::ST_SUM:
            begin
                if (is_last)
                begin
                    if (sum_bad)
                    begin
                        rd_ptr_next = wrap_add(rd_ptr_reg, 6'd1);
                        fill_next   = fill_reg - CNT_W'(1);
                    end
                    else
                    begin
                        idx_next = '0;
                        raddr    = rd_ptr_reg;
                    end
                end
                else
                begin
                    sum_next = sum_reg ^ rdata_reg;
                    idx_next = idx_reg + 6'd1;
                    raddr    = wrap_add(rd_ptr_reg, idx_reg + 6'd1);
                end
            end
            rbpd_pkg::ST_EMIT:
            begin
                push_valid = !queue_full;
                if (!queue_full)
                begin
                    if (is_last)
                    begin
                        rd_ptr_next = wrap_add(rd_ptr_reg, len_reg);
                        fill_next   = fill_reg - CNT_W'(len_reg);
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                        raddr    = wrap_add(rd_ptr_reg, idx_reg + 6'd1);
                    end
                end
                else
                begin
                    // Re-read the same byte so that the read register holds it.
                    raddr = wrap_add(rd_ptr_reg, idx_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/rbpd_queue.sv =====
// Short beat queue between the parse front end and the output stage.
// Depends on rbpd_pkg for the beat type and the queue depth.
`default_nettype none

module rbpd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    input  wire rbpd_pkg::beat_t    push_beat,
    output logic                    full,
    output logic                    pop_valid,
    output rbpd_pkg::beat_t         pop_beat,
    input  wire logic               pop_ready
);

    rbpd_pkg::beat_t                    entry_reg [rbpd_pkg::QUEUE_DEPTH];
    logic [rbpd_pkg::QPTR_W-1:0]        head_reg, head_next;
    logic [rbpd_pkg::QPTR_W-1:0]        tail_reg, tail_next;
    logic [rbpd_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                               do_push;
    logic                               do_pop;

    assign full      = count_reg == rbpd_pkg::QCNT_W'(rbpd_pkg::QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_beat  = entry_reg[head_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_comb
    begin
        head_next  = do_pop ? head_reg + rbpd_pkg::QPTR_W'(1) : head_reg;
        tail_next  = do_push ? tail_reg + rbpd_pkg::QPTR_W'(1) : tail_reg;
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + rbpd_pkg::QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - rbpd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[tail_reg] <= push_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rbpd_back.sv =====
// Back end: output register that drives the packet channel from the queue.
// Depends on rbpd_pkg and rbpd_out_if.
`default_nettype none

module rbpd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire rbpd_pkg::beat_t    q_beat,
    output logic                    q_ready,
    rbpd_out_if.source              tx
);

    logic               valid_reg, valid_next;
    rbpd_pkg::beat_t    beat_reg;
    logic               take;

    assign q_ready    = !valid_reg || tx.ready;
    assign take       = q_valid && q_ready;
    assign valid_next = take || (valid_reg && !tx.ready);

    assign tx.valid          = valid_reg;
    assign tx.packet_byte    = beat_reg.packet_byte;
    assign tx.last_of_packet = beat_reg.last_of_packet;
    assign tx.packet_length  = beat_reg.packet_length;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            beat_reg <= q_beat;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ring_buffered_packet_deframer_core.sv =====
// Top level of the ring-buffered packet deframer: front end, beat queue, output stage.
// Depends on rbpd_pkg, the three channel interfaces, rbpd_front, rbpd_queue, rbpd_back.
//
//   channel  dir  beat contents                                  handshake
//   rx       in   rx_byte                                        valid/ready
//   tx       out  packet_byte, last_of_packet, packet_length     valid/ready
//   cfg      in   index, data (0 header, 1 min, 2 max length)    valid/ready
//
// A received byte is taken in the idle state, then the parse pass runs in the front end: the
// header test, the length test, the length and checksum walk and the move of a valid packet
// into the queue all read through the single ring read port, one byte at a time. rx is ready
// again only once the pass is over.
// Reset empties the ring at once through its fill count; there is no clearing pass.
// Stalls on tx fill the four-beat queue and then hold the front end, never the cfg port.
`default_nettype none

module ring_buffered_packet_deframer_core #(
    parameter int BUFFER_DEPTH = rbpd_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    rbpd_in_if.sink     rx,
    rbpd_out_if.source  tx,
    rbpd_cfg_if.sink    cfg
);

    logic               push_valid;
    rbpd_pkg::beat_t    push_beat;
    logic               queue_full;
    logic               q_valid;
    rbpd_pkg::beat_t    q_beat;
    logic               q_ready;

    rbpd_front #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx         (rx),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_beat  (push_beat),
        .queue_full (queue_full)
    );

    rbpd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_beat  (push_beat),
        .full       (queue_full),
        .pop_valid  (q_valid),
        .pop_beat   (q_beat),
        .pop_ready  (q_ready)
    );

    rbpd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_beat  (q_beat),
        .q_ready (q_ready),
        .tx      (tx)
    );

endmodule

`default_nettype wire

// ===== tb/ring_buffered_packet_deframer_core_chk.sv =====
// Checker for the ring-buffered packet deframer: watches the rx, tx and cfg channels,
// keeps its own copy of the ring and the registers, and compares every tx beat.
// Depends on rbpd_pkg and the three channel interfaces.

module ring_buffered_packet_deframer_core_chk
    import rbpd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    rbpd_in_if        rx,
    rbpd_out_if       tx,
    rbpd_cfg_if       cfg,
    output int        error_count,
    output int        pending_beats,
    output int        bytes_taken,
    output int        beats_taken,
    output int        packets_taken
);

    localparam int RING_DEPTH = BUFFER_DEPTH_DEF;
    localparam int PTR_W      = $clog2(RING_DEPTH);

    logic [7:0]       ring_q [RING_DEPTH];
    logic [PTR_W-1:0] rd_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W:0]   fill;
    logic [7:0]       hdr_byte;
    logic [5:0]       min_len;
    logic [5:0]       max_len;
    beat_t            expected_beats[$];
    beat_t            want;

    function automatic logic [7:0] ring_at(input int off);
        return ring_q[PTR_W'(rd_ptr + off)];
    endfunction

    task automatic deframe_byte(input logic [7:0] b);
        int         floor_len;
        int         len;
        logic [7:0] sum;
        bit         scanning;
        bit         keep;
        floor_len = (min_len < MIN_LENGTH_FLOOR) ? MIN_LENGTH_FLOOR : min_len;
        if (fill < RING_DEPTH)
        begin
            ring_q[wr_ptr] = b;
            wr_ptr = wr_ptr + 1'b1;
            fill = fill + 1'b1;
        end
        scanning = 1'b1;
        while (scanning && fill >= floor_len)
        begin
            len = ring_at(1);
            keep = (ring_at(0) == hdr_byte) && len >= floor_len && len <= max_len
                   && len <= RING_DEPTH;
            if (keep && fill < len)
            begin
                scanning = 1'b0;
            end
            else
            begin
                if (keep)
                begin
                    sum = '0;
                    for (int i = 0; i + 1 < len; i++)
                        sum ^= ring_at(i);
                    keep = (sum == ring_at(len - 1));
                end
                if (keep)
                begin
                    for (int i = 0; i < len; i++)
                    begin
                        want.packet_byte    = ring_at(i);
                        want.last_of_packet = (i + 1 == len);
                        want.packet_length  = 6'(len);
                        expected_beats.push_back(want);
                    end
                    rd_ptr = PTR_W'(rd_ptr + len);
                    fill = fill - (PTR_W + 1)'(len);
                    scanning = 1'b0;
                end
                else
                begin
                    rd_ptr = rd_ptr + 1'b1;
                    fill = fill - 1'b1;
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr = '0;
            wr_ptr = '0;
            fill = '0;
            hdr_byte = HEADER_BYTE_RST;
            min_len = MIN_LENGTH_RST;
            max_len = MAX_LENGTH_RST;
            expected_beats.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_HEADER_BYTE: hdr_byte = cfg.data;
                    CFG_MIN_LENGTH:  min_len = cfg.data[5:0];
                    CFG_MAX_LENGTH:  max_len = cfg.data[5:0];
                    default: ;
                endcase
            end
            if (rx.valid && rx.ready)
            begin
                bytes_taken++;
                deframe_byte(rx.rx_byte);
            end
            if (tx.valid && tx.ready)
            begin
                beats_taken++;
                if (tx.last_of_packet)
                    packets_taken++;
                if (expected_beats.size() == 0)
                begin
                    $error("packet beat %02h arrived with no packet expected", tx.packet_byte);
                    error_count++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (tx.packet_byte !== want.packet_byte)
                    begin
                        $error("packet_byte: expected %02h, got %02h",
                               want.packet_byte, tx.packet_byte);
                        error_count++;
                    end
                    if (tx.last_of_packet !== want.last_of_packet)
                    begin
                        $error("last_of_packet: expected %0b, got %0b",
                               want.last_of_packet, tx.last_of_packet);
                        error_count++;
                    end
                    if (tx.packet_length !== want.packet_length)
                    begin
                        $error("packet_length: expected %0d, got %0d",
                               want.packet_length, tx.packet_length);
                        error_count++;
                    end
                end
            end
        end
        pending_beats = expected_beats.size();
    end

endmodule

// ===== tb/ring_buffered_packet_deframer_core_tb.sv =====
// Top of the deframer regression: clock, reset, rx and cfg stimulus, tx back-pressure
// and the verdict. Depends on rbpd_pkg, the channel interfaces, the block and its checker.

module ring_buffered_packet_deframer_core_tb;
    import rbpd_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
    localparam int     SETTLE_CYCLES = 400;
    localparam int     DRAIN_LIMIT   = 20000;
    localparam longint RUN_LIMIT     = 64'd8_000_000;
    localparam logic [7:0] OPENING [0:17] = '{
        8'h00, 8'hFF,
        8'hAA, 8'hC8,
        8'hAA, 8'h02,
        8'hAA, 8'h40,
        8'hAA, 8'h03, 8'hA9,
        8'hAA, 8'h04, 8'hFF, 8'h51,
        8'hAA, 8'h03, 8'h00
    };

    logic       clk;
    logic       rst_n;
    bit         idle_on;
    bit         stall_on;
    logic [7:0] cur_hdr;
    int         cur_min;
    int         cur_max;
    int         items_sent;
    int         settings_run;
    int         err_count;
    int         beats_left;
    int         bytes_taken;
    int         beats_taken;
    int         packets_taken;

    rbpd_in_if  rx_ch();
    rbpd_out_if tx_ch();
    rbpd_cfg_if cfg_ch();

    ring_buffered_packet_deframer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .tx    (tx_ch),
        .cfg   (cfg_ch)
    );

    ring_buffered_packet_deframer_core_chk u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .rx            (rx_ch),
        .tx            (tx_ch),
        .cfg           (cfg_ch),
        .error_count   (err_count),
        .pending_beats (beats_left),
        .bytes_taken   (bytes_taken),
        .beats_taken   (beats_taken),
        .packets_taken (packets_taken)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("ring_buffered_packet_deframer_core regression: fail");
        $finish;
    end

    initial
    begin
        tx_ch.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (stall_on && $urandom_range(0, 2) == 0)
            begin
                tx_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
            end
            tx_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    end

    task automatic send_rx(input logic [7:0] b);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        rx_ch.valid <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge clk);
        while (!rx_ch.ready) @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= value;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    // The front end may still be scanning after the last packet beat, hence the pause.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        @(negedge clk);
        while (beats_left != 0 || !rx_ch.ready) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apply_setting(input logic [7:0] hdr, input logic [5:0] lo,
                                 input logic [5:0] hi);
        settle();
        write_reg(CFG_HEADER_BYTE, hdr);
        write_reg(CFG_MIN_LENGTH, {2'($urandom_range(0, 3)), lo});
        write_reg(CFG_MAX_LENGTH, {2'($urandom_range(0, 3)), hi});
        cur_hdr = hdr;
        cur_min = lo;
        cur_max = hi;
        settings_run++;
    endtask

    task automatic send_frame(input logic [7:0] len_byte, input int body_len,
                              input bit corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = cur_hdr ^ len_byte;
        send_rx(cur_hdr);
        send_rx(len_byte);
        repeat (body_len)
        begin
            b = 8'($urandom);
            sum ^= b;
            send_rx(b);
        end
        if (corrupt)
            sum ^= 8'($urandom_range(1, 255));
        send_rx(sum);
    endtask

    // Mostly well-formed packets of short length, with corrupted checksums,
    // bad length bytes and loose noise mixed in.
    task automatic random_phase(input int budget);
        int first;
        int lo;
        int hi;
        int len;
        first = items_sent;
        lo = (cur_min < MIN_LENGTH_FLOOR) ? MIN_LENGTH_FLOOR : cur_min;
        hi = cur_max;
        while (items_sent - first < budget)
        begin
            if (lo > hi)
                len = $urandom_range(3, 12);
            else if ($urandom_range(0, 9) == 0)
                len = $urandom_range(lo, hi);
            else
                len = $urandom_range(lo, (hi - lo > 6) ? lo + 6 : hi);
            case ($urandom_range(0, 9))
                0: send_frame(8'(len), len - 3, 1'b1);
                1: send_frame(8'($urandom), $urandom_range(0, 3), 1'b0);
                2: repeat ($urandom_range(1, 4))
                       send_rx($urandom_range(0, 1) ? cur_hdr : 8'($urandom));
                default: send_frame(8'(len), len - 3, 1'b0);
            endcase
        end
    endtask

    initial
    begin
        int guard;
        rx_ch.valid = 1'b0;
        rx_ch.rx_byte = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = CFG_HEADER_BYTE;
        cfg_ch.data = '0;
        rst_n = 1'b0;
        idle_on = 1'b1;
        stall_on = 1'b1;
        cur_hdr = HEADER_BYTE_RST;
        cur_min = MIN_LENGTH_RST;
        cur_max = MAX_LENGTH_RST;
        items_sent = 0;
        settings_run = 1;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < 18; i++)
            send_rx(OPENING[i]);
        settle();
        write_reg(CFG_SPARE, 8'($urandom));
        send_frame(8'd5, 2, 1'b0);
        random_phase(55);

        apply_setting(8'h00, 6'd0, 6'd63);
        random_phase(60);
        apply_setting(8'hFF, 6'd1, 6'd3);
        random_phase(40);
        apply_setting(8'($urandom), 6'd2, 6'd10);
        random_phase(30);
        settle();
        random_phase(30);
        apply_setting(8'($urandom), 6'd40, 6'd0);
        random_phase(30);
        apply_setting(8'($urandom), 6'd63, 6'd63);
        random_phase(70);
        apply_setting(8'($urandom), 6'($urandom_range(3, 8)), 6'($urandom_range(8, 63)));
        idle_on = 1'b0;
        stall_on = 1'b0;
        random_phase(65);

        rx_ch.valid <= 1'b0;
        guard = 0;
        while (beats_left != 0 && guard < DRAIN_LIMIT)
        begin
            @(negedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (beats_left != 0)
            $error("%0d expected packet beats never arrived", beats_left);
        $display("Covered %0d received bytes under %0d register settings,",
                 bytes_taken, settings_run);
        $display("plus a spare-index write; checked %0d packets carrying %0d beats.",
                 packets_taken, beats_taken);
        if (err_count == 0 && beats_left == 0)
            $display("ring_buffered_packet_deframer_core regression: pass");
        else
            $display("ring_buffered_packet_deframer_core regression: fail");
        $finish;
    end

endmodule
